/* rtl/urb_pkg.sv */
`default_nettype none

package urb_pkg;

  localparam int RX_DEPTH = 8;
  localparam int TX_DEPTH = 8;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_CW    = RX_AW + 1;
  localparam int TX_CW    = TX_AW + 1;
  localparam int KIND_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 3;

  typedef enum logic [KIND_W-1:0] {
    K_LINE_RX   = 3'd0,
    K_HOST_READ = 3'd1,
    K_HOST_SEND = 3'd2,
    K_TX_READY  = 3'd3,
    K_TX_DONE   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [BYTE_W-1:0]  read_data;
    logic               line_out_valid;
    logic [BYTE_W-1:0]  line_out_byte;
    logic               transmitter_on;
    logic [COUNT_W-1:0] rx_count;
    logic [COUNT_W-1:0] tx_count;
  } out_item_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/urb_ctrl.sv */
`default_nettype none

module urb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output urb_pkg::dp_cmd_t      cmd
);
  import urb_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/urb_datapath.sv */
`default_nettype none

module urb_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire urb_pkg::dp_cmd_t  cmd,
  input  wire urb_pkg::in_item_t in_data,
  input  wire logic              cfg_we,
  input  wire logic              cfg_data,
  output urb_pkg::out_item_t     out_data
);
  import urb_pkg::*;

  logic [BYTE_W-1:0]  rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0]  tx_mem [TX_DEPTH];
  logic [RX_DEPTH-1:0] rx_vld_r;

  in_item_t           item_r;
  logic [BYTE_W-1:0]  rx_rd_r;
  logic               rx_rd_vld_r;
  logic [BYTE_W-1:0]  tx_rd_r;

  logic [RX_AW-1:0]   rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt, rx_head_inc, rx_tail_inc;
  logic [TX_AW-1:0]   tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt, tx_head_inc, tx_tail_inc;
  logic               sent_r, sent_nxt;
  logic               active_r, active_nxt;
  logic               half_duplex_r;
  logic               rx_we, tx_we, rx_room;
  logic [RX_CW-1:0]   rx_cnt;
  logic [TX_CW-1:0]   tx_cnt;
  out_item_t          res;
  out_item_t          out_r;

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_head_r] <= item_r.data;
    end
    if (tx_we) begin
      tx_mem[tx_head_r] <= item_r.data;
    end
    if (cmd.capture) begin
      item_r  <= in_data;
      rx_rd_r <= rx_mem[rx_tail_r];
      tx_rd_r <= tx_mem[tx_tail_r];
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_vld_r      <= '0;
      rx_rd_vld_r   <= 1'b0;
      rx_head_r     <= '0;
      rx_tail_r     <= '0;
      tx_head_r     <= '0;
      tx_tail_r     <= '0;
      sent_r        <= 1'b0;
      active_r      <= 1'b0;
      half_duplex_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        half_duplex_r <= cfg_data;
      end
      if (cmd.capture) begin
        rx_rd_vld_r <= rx_vld_r[rx_tail_r];
      end
      if (rx_we) begin
        rx_vld_r[rx_head_r] <= 1'b1;
      end
      if (cmd.commit) begin
        rx_head_r <= rx_head_nxt;
        rx_tail_r <= rx_tail_nxt;
        tx_head_r <= tx_head_nxt;
        tx_tail_r <= tx_tail_nxt;
        sent_r    <= sent_nxt;
        active_r  <= active_nxt;
      end
    end
  end

  always_comb begin
    rx_head_inc = (rx_head_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_r + RX_AW'(1);
    rx_tail_inc = (rx_tail_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_r + RX_AW'(1);
    tx_head_inc = (tx_head_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_r + TX_AW'(1);
    tx_tail_inc = (tx_tail_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_r + TX_AW'(1);

    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    sent_nxt    = sent_r;
    active_nxt  = active_r;
    rx_we       = 1'b0;
    tx_we       = 1'b0;
    rx_room     = 1'b0;
    res         = '0;

    case (kind_t'(item_r.kind))
      K_LINE_RX: begin
        rx_room = (rx_head_inc != rx_tail_r) &&
                  (!half_duplex_r || ((tx_head_r == tx_tail_r) && !sent_r));
        if (rx_room) begin
          rx_we        = cmd.commit;
          rx_head_nxt  = rx_head_inc;
          res.accepted = 1'b1;
        end
        sent_nxt = 1'b0;
      end
      K_HOST_READ: begin
        res.read_data = rx_rd_vld_r ? rx_rd_r : '0;
        if (rx_tail_r != rx_head_r) begin
          rx_tail_nxt  = rx_tail_inc;
          res.accepted = 1'b1;
        end
      end
      K_HOST_SEND: begin
        if (tx_head_inc != tx_tail_r) begin
          tx_we        = cmd.commit;
          tx_head_nxt  = tx_head_inc;
          active_nxt   = 1'b1;
          res.accepted = 1'b1;
        end
      end
      K_TX_READY: begin
        if (tx_tail_r != tx_head_r) begin
          res.line_out_byte  = tx_rd_r;
          res.line_out_valid = 1'b1;
          tx_tail_nxt        = tx_tail_inc;
          res.accepted       = 1'b1;
        end else begin
          active_nxt = 1'b0;
        end
      end
      K_TX_DONE: begin
        sent_nxt = 1'b1;
      end
      default: begin
        sent_nxt = sent_r;
      end
    endcase

    rx_cnt = RX_CW'(rx_head_nxt) - RX_CW'(rx_tail_nxt);
    if (rx_head_nxt < rx_tail_nxt) begin
      rx_cnt = rx_cnt + RX_CW'(RX_DEPTH);
    end
    tx_cnt = TX_CW'(tx_head_nxt) - TX_CW'(tx_tail_nxt);
    if (tx_head_nxt < tx_tail_nxt) begin
      tx_cnt = tx_cnt + TX_CW'(TX_DEPTH);
    end
    res.transmitter_on = active_nxt;
    res.rx_count       = COUNT_W'(rx_cnt);
    res.tx_count       = COUNT_W'(tx_cnt);
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

/* rtl/uart_ring_buffers_half_duplex.sv */
`default_nettype none

// Receive and transmit byte rings on the UART side, each holding one byte fewer than its
// depth. Each item is one event (line byte received, host read, host send, transmitter
// ready, transmission complete) and yields exactly one result item. The accept cycle of an
// item reads both rings at their tails into registered read data; a later cycle in which
// the result register is free updates pointers and flags and loads the result register.
// A new item is taken as soon as the result is loaded, even while that result still waits
// downstream. The receive ring reads as zero in entries never written since reset; no
// clearing pass is needed. Writing cfg_data to one enables half-duplex mode, in which a
// received byte is dropped while the transmit ring holds data or when it is the first
// received byte after a transmission completed.
module uart_ring_buffers_half_duplex (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire urb_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output urb_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);
  import urb_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  urb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  urb_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

/* rtl/urb_checker.sv */
`default_nettype none

module urb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire urb_pkg::out_item_t out_data
);
  import urb_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while another was in progress");

  a_line_out_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.line_out_valid |-> out_data.accepted && out_data.transmitter_on)
    else $error("line byte handed out without acceptance or with transmitter off");

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind uart_ring_buffers_half_duplex urb_checker u_urb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

/* dv/tb_uart_ring_buffers_half_duplex.sv */
`default_nettype none

module tb_uart_ring_buffers_half_duplex;
  timeunit 1ns;
  timeprecision 1ps;

  import urb_pkg::*;

  localparam int IDLE_LIMIT = 500;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  in_item_t    event_queue[$];
  out_item_t   awaited_results[$];
  out_item_t   oldest_result;
  int unsigned events_queued  = 0;
  int unsigned events_taken   = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_gap       = 0;
  int unsigned hold_gap       = 0;
  logic        in_took        = 1'b0;
  bit          calm           = 1'b0;

  logic [BYTE_W-1:0] rx_ring [RX_DEPTH] = '{default: '0};
  logic [BYTE_W-1:0] tx_ring [TX_DEPTH] = '{default: '0};
  logic [RX_AW-1:0]  rx_wr = '0;
  logic [RX_AW-1:0]  rx_rd = '0;
  logic [TX_AW-1:0]  tx_wr = '0;
  logic [TX_AW-1:0]  tx_rd = '0;
  bit                echo_guard       = 1'b0;
  bit                tx_enabled       = 1'b0;
  bit                half_duplex_mode = 1'b1;

  uart_ring_buffers_half_duplex uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic out_item_t predict_event(in_item_t ev);
    out_item_t        r;
    logic [RX_AW-1:0] rx_next;
    logic [TX_AW-1:0] tx_next;
    r = '0;
    rx_next = rx_wr + RX_AW'(1);
    tx_next = tx_wr + TX_AW'(1);
    case (ev.kind)
      K_LINE_RX: begin
        if (rx_next != rx_rd && (!half_duplex_mode || (tx_wr == tx_rd && !echo_guard))) begin
          rx_ring[rx_wr] = ev.data;
          rx_wr = rx_next;
          r.accepted = 1'b1;
        end
        echo_guard = 1'b0;
      end
      K_HOST_READ: begin
        r.read_data = rx_ring[rx_rd];
        if (rx_rd != rx_wr) begin
          rx_rd = rx_rd + RX_AW'(1);
          r.accepted = 1'b1;
        end
      end
      K_HOST_SEND: begin
        if (tx_next != tx_rd) begin
          tx_enabled = 1'b1;
          tx_ring[tx_wr] = ev.data;
          tx_wr = tx_next;
          r.accepted = 1'b1;
        end
      end
      K_TX_READY: begin
        if (tx_rd != tx_wr) begin
          r.line_out_valid = 1'b1;
          r.line_out_byte = tx_ring[tx_rd];
          tx_rd = tx_rd + TX_AW'(1);
          r.accepted = 1'b1;
        end else begin
          tx_enabled = 1'b0;
        end
      end
      K_TX_DONE: echo_guard = 1'b1;
      default: ;
    endcase
    r.transmitter_on = tx_enabled;
    r.rx_count = COUNT_W'(rx_wr - rx_rd);
    r.tx_count = COUNT_W'(tx_wr - tx_rd);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] got,
                             input logic [BYTE_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  task automatic queue_event(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data);
    in_item_t ev;
    ev.kind = kind;
    ev.data = data;
    event_queue.push_back(ev);
    events_queued++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return BYTE_W'($urandom_range(0, (1 << BYTE_W) - 1));
    endcase
  endfunction

  task automatic queue_random_events(input int unsigned count);
    int unsigned       stop_at;
    int unsigned       n;
    int unsigned       rounds;
    logic [KIND_W-1:0] noise_kind;
    stop_at = events_queued + count;
    while (events_queued < stop_at) begin
      n = $urandom_range(1, 9);
      case ($urandom_range(0, 9))
        0, 1, 2: repeat (n) queue_event(K_LINE_RX, pick_byte());
        3, 4: repeat (n) queue_event(K_HOST_READ, pick_byte());
        5, 6, 7: begin
          repeat (n) queue_event(K_HOST_SEND, pick_byte());
          rounds = n + $urandom_range(1, 3);
          repeat (rounds) begin
            queue_event(K_TX_READY, pick_byte());
            if ($urandom_range(0, 3) != 0) queue_event(K_TX_DONE, pick_byte());
          end
          if ($urandom_range(0, 1) != 0) queue_event(K_LINE_RX, pick_byte());
        end
        default: begin
          repeat (n) begin
            if ($urandom_range(0, 15) == 0) begin
              noise_kind = KIND_W'($urandom_range(int'(K_TX_DONE) + 1, (1 << KIND_W) - 1));
            end else begin
              noise_kind = KIND_W'($urandom_range(0, int'(K_TX_DONE)));
            end
            queue_event(noise_kind, pick_byte());
          end
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (events_taken != events_queued || awaited_results.size() != 0);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (event_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= event_queue.pop_front();
        if (!calm && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_gap > 0) begin
      hold_gap  <= hold_gap - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      hold_gap  <= $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        awaited_results.push_back(predict_event(in_data));
        events_taken++;
      end
      if (cfg_valid && cfg_ready) half_duplex_mode = cfg_data;
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result item %h with nothing expected", out_data));
        end else begin
          oldest_result = awaited_results.pop_front();
          check_field("accepted", BYTE_W'(out_data.accepted),
                      BYTE_W'(oldest_result.accepted));
          check_field("read_data", out_data.read_data, oldest_result.read_data);
          check_field("line_out_valid", BYTE_W'(out_data.line_out_valid),
                      BYTE_W'(oldest_result.line_out_valid));
          check_field("line_out_byte", out_data.line_out_byte, oldest_result.line_out_byte);
          check_field("transmitter_on", BYTE_W'(out_data.transmitter_on),
                      BYTE_W'(oldest_result.transmitter_on));
          check_field("rx_count", BYTE_W'(out_data.rx_count),
                      BYTE_W'(oldest_result.rx_count));
          check_field("tx_count", BYTE_W'(out_data.tx_count),
                      BYTE_W'(oldest_result.tx_count));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("uart_ring_buffers_half_duplex test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] fill_bytes [8];
    fill_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'h3C};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Half-duplex from reset: fill the receive ring past full, drain it, then
    // check that local transmission blocks reception and the echo is dropped.
    queue_event(K_TX_READY, 8'h00);
    foreach (fill_bytes[i]) queue_event(K_LINE_RX, fill_bytes[i]);
    repeat (8) queue_event(K_HOST_READ, 8'hFF);
    queue_event(K_HOST_SEND, 8'hFF);
    queue_event(K_LINE_RX, 8'h12);
    queue_event(K_TX_READY, 8'h00);
    queue_event(K_TX_DONE, 8'h00);
    queue_event(K_LINE_RX, 8'h34);
    queue_event(K_LINE_RX, 8'h56);
    for (int k = int'(K_TX_DONE) + 1; k < (1 << KIND_W); k++) begin
      queue_event(KIND_W'(k), 8'hA5);
    end
    wait_drained();

    write_mode(1'b1);
    queue_random_events(300);
    wait_drained();

    // Full-duplex: reception goes on while transmitting and after a sent byte.
    write_mode(1'b0);
    queue_event(K_HOST_SEND, 8'h5A);
    queue_event(K_LINE_RX, 8'hC3);
    queue_event(K_TX_READY, 8'h00);
    queue_event(K_TX_DONE, 8'h00);
    queue_event(K_LINE_RX, 8'h3C);
    queue_random_events(300);
    wait_drained();

    write_mode(1'b1);
    queue_random_events(220);
    wait_drained();

    calm = 1'b1;
    queue_random_events(100);
    wait_drained();
    repeat (8) @(posedge clk);

    if (awaited_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", awaited_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("uart_ring_buffers_half_duplex test passed");
    end else begin
      $display("uart_ring_buffers_half_duplex test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
